[sv/dsr_pkg.sv]
// ----------------------------------------------------------------------------
// dsr_pkg - shared types and constants of the diamond span rasterizer
// Field widths, register indexes, reset values and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dsr_pkg;

  localparam int unsigned MAX_RADIUS_DEF = 31;

  // field widths
  localparam int unsigned CENTER_W = 15;
  localparam int unsigned RADIUS_W = 5;
  localparam int unsigned RGBA_W   = 32;
  localparam int unsigned OUT_W    = 16;
  localparam int unsigned CLIP_W   = 12;
  localparam int unsigned SIZE_W   = 13;
  localparam int unsigned SHADE_W  = 7;
  localparam int unsigned ALPHA_W  = 8;

  // wide enough for centre +/- radius and clip right/bottom, signed
  localparam int unsigned COORD_W  = 17;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_LEFT   = 3'd0,
    CFG_CLIP_TOP    = 3'd1,
    CFG_CLIP_WIDTH  = 3'd2,
    CFG_CLIP_HEIGHT = 3'd3,
    CFG_SCAN_EN     = 3'd4,
    CFG_SHADE       = 3'd5
  } cfg_idx_t;

  localparam logic [CLIP_W-1:0]  CLIP_LEFT_RST   = '0;
  localparam logic [CLIP_W-1:0]  CLIP_TOP_RST    = '0;
  localparam logic [SIZE_W-1:0]  CLIP_WIDTH_RST  = 13'd4096;
  localparam logic [SIZE_W-1:0]  CLIP_HEIGHT_RST = 13'd4096;
  localparam logic [SHADE_W-1:0] SHADE_RST       = 7'd100;

  // alpha * shade / 100: exact reciprocal for products below 2^15
  localparam int unsigned PROD_W       = ALPHA_W + SHADE_W;
  localparam int unsigned RECIP_W      = 15;
  localparam logic [RECIP_W-1:0] SHADE_RECIP = 15'd20972;
  localparam int unsigned SHADE_SHIFT  = 21;
  localparam int unsigned QUOT_W       = PROD_W + RECIP_W - SHADE_SHIFT;
  localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'hFF;

  typedef struct packed {
    logic load;   // latch a new command
    logic mul;    // alpha * shade
    logic prep;   // scale, bounding box check
    logic emit;   // drive one span beat
  } dsr_cmd_t;

  typedef struct packed {
    logic last;   // current span is the command's final beat
  } dsr_status_t;

endpackage

[sv/dsr_ctrl.sv]
// ----------------------------------------------------------------------------
// dsr_ctrl - command sequencer
// Accepts a draw command, runs the mul and prep set-up states, then emits
// spans until the datapath reports the final one.
// ----------------------------------------------------------------------------
module dsr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output dsr_pkg::dsr_cmd_t    cmd,
  input  dsr_pkg::dsr_status_t status
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_PREP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_MUL;
      end
      ST_MUL:  state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (status.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign cmd.load  = start && (state_r == ST_IDLE);
  assign cmd.mul   = (state_r == ST_MUL);
  assign cmd.prep  = (state_r == ST_PREP);
  assign cmd.emit  = (state_r == ST_EMIT);

endmodule

[sv/dsr_datapath.sv]
// ----------------------------------------------------------------------------
// dsr_datapath - span generator
// Holds the command and clip registers, scales alpha once per command,
// walks the span index and registers one clipped span per emit beat.
// ----------------------------------------------------------------------------
module dsr_datapath #(
  parameter int unsigned MAX_RADIUS = dsr_pkg::MAX_RADIUS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dsr_pkg::dsr_cmd_t                     cmd,
  output dsr_pkg::dsr_status_t                  status,
  input  logic signed [dsr_pkg::CENTER_W-1:0]   in_center_x,
  input  logic signed [dsr_pkg::CENTER_W-1:0]   in_center_y,
  input  logic        [dsr_pkg::RADIUS_W-1:0]   in_radius,
  input  logic        [dsr_pkg::RGBA_W-1:0]     in_rgba,
  input  logic                                  cfg_we,
  input  logic        [dsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [dsr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                                  out_strobe,
  output logic                                  out_visible,
  output logic signed [dsr_pkg::OUT_W-1:0]      out_row,
  output logic signed [dsr_pkg::OUT_W-1:0]      out_x_start,
  output logic signed [dsr_pkg::OUT_W-1:0]      out_x_end,
  output logic        [dsr_pkg::RGBA_W-1:0]     out_span_rgba,
  output logic                                  out_last
);

  localparam int unsigned STEP_W = $clog2(2 * MAX_RADIUS + 2);
  localparam int unsigned CW     = dsr_pkg::COORD_W;
  localparam int unsigned RW     = dsr_pkg::RADIUS_W;
  localparam logic [RW-1:0] R_MAX = RW'(MAX_RADIUS);

  // configuration
  logic [dsr_pkg::CLIP_W-1:0]  clip_left_r, clip_top_r;
  logic [dsr_pkg::SIZE_W-1:0]  clip_width_r, clip_height_r;
  logic                        scan_en_r;
  logic [dsr_pkg::SHADE_W-1:0] shade_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r   <= dsr_pkg::CLIP_LEFT_RST;
      clip_top_r    <= dsr_pkg::CLIP_TOP_RST;
      clip_width_r  <= dsr_pkg::CLIP_WIDTH_RST;
      clip_height_r <= dsr_pkg::CLIP_HEIGHT_RST;
      scan_en_r     <= 1'b0;
      shade_r       <= dsr_pkg::SHADE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dsr_pkg::CFG_CLIP_LEFT:   clip_left_r   <= cfg_wdata[dsr_pkg::CLIP_W-1:0];
        dsr_pkg::CFG_CLIP_TOP:    clip_top_r    <= cfg_wdata[dsr_pkg::CLIP_W-1:0];
        dsr_pkg::CFG_CLIP_WIDTH:  clip_width_r  <= cfg_wdata;
        dsr_pkg::CFG_CLIP_HEIGHT: clip_height_r <= cfg_wdata;
        dsr_pkg::CFG_SCAN_EN:     scan_en_r     <= cfg_wdata[0];
        dsr_pkg::CFG_SHADE:       shade_r       <= cfg_wdata[dsr_pkg::SHADE_W-1:0];
        default: ;
      endcase
    end
  end

  // held command
  logic signed [dsr_pkg::CENTER_W-1:0] cx_r, cy_r;
  logic        [RW-1:0]                rad_r;
  logic        [dsr_pkg::RGBA_W-1:0]   rgba_r;
  logic        [STEP_W-1:0]            step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= '0;
      cy_r   <= '0;
      rad_r  <= '0;
      rgba_r <= '0;
    end else if (cmd.load) begin
      cx_r   <= in_center_x;
      cy_r   <= in_center_y;
      rad_r  <= (in_radius > R_MAX) ? R_MAX : in_radius;
      rgba_r <= in_rgba;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.load) begin
      step_r <= '0;
    end else if (cmd.emit) begin
      step_r <= step_r + 1'b1;
    end
  end

  // clip bounds, wide and signed
  logic signed [CW-1:0] left_w, top_w, right_w, bottom_w;
  logic signed [CW-1:0] cx_w, cy_w, rad_w;

  assign left_w   = signed'(CW'(clip_left_r));
  assign top_w    = signed'(CW'(clip_top_r));
  assign right_w  = signed'(CW'(clip_left_r) + CW'(clip_width_r) - CW'(1));
  assign bottom_w = signed'(CW'(clip_top_r) + CW'(clip_height_r) - CW'(1));
  assign cx_w     = CW'(cx_r);
  assign cy_w     = CW'(cy_r);
  assign rad_w    = signed'(CW'(rad_r));

  // alpha scaling: product registered on mul, saturated quotient on prep
  logic [dsr_pkg::PROD_W-1:0]                     prod_r;
  logic [dsr_pkg::PROD_W+dsr_pkg::RECIP_W-1:0]    recip_prod;
  logic [dsr_pkg::QUOT_W-1:0]                     quot;
  logic [dsr_pkg::ALPHA_W-1:0]                    alpha_sh_r;
  logic                                           miss_r, miss;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= dsr_pkg::PROD_W'(rgba_r[dsr_pkg::ALPHA_W-1:0]) *
                dsr_pkg::PROD_W'(shade_r);
    end
  end

  assign recip_prod = prod_r * dsr_pkg::SHADE_RECIP;
  assign quot       = recip_prod[dsr_pkg::PROD_W+dsr_pkg::RECIP_W-1:dsr_pkg::SHADE_SHIFT];

  // empty rectangle or bounding box wholly outside it
  assign miss = (clip_width_r == '0) || (clip_height_r == '0) ||
                (cx_w + rad_w < left_w) || (cx_w - rad_w > right_w) ||
                (cy_w + rad_w < top_w)  || (cy_w - rad_w > bottom_w);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      alpha_sh_r <= (quot > dsr_pkg::QUOT_W'(dsr_pkg::ALPHA_MAX)) ?
                    dsr_pkg::ALPHA_MAX : quot[dsr_pkg::ALPHA_W-1:0];
      miss_r     <= miss;
    end
  end

  // span index: 0 centre row, odd rows above, even rows below
  logic              centre, above, span_last;
  logic [STEP_W-1:0] step_m1;
  logic [RW-1:0]     half_w, row_off;
  logic signed [CW-1:0] hw_w, row_off_w, x1, x2, y, x1c, x2c;
  logic              vis;
  logic [dsr_pkg::RGBA_W-1:0] col;

  assign centre    = (step_r == '0);
  assign above     = step_r[0];
  assign step_m1   = step_r - 1'b1;
  assign half_w    = centre ? rad_r : RW'(step_m1[STEP_W-1:1]);
  assign row_off   = rad_r - half_w;
  assign hw_w      = signed'(CW'(half_w));
  assign row_off_w = signed'(CW'(row_off));

  assign span_last = miss_r || (step_r == STEP_W'({rad_r, 1'b0}));

  assign x1 = cx_w - hw_w;
  assign x2 = cx_w + hw_w;
  always_comb begin
    priority if (centre) y = cy_w;
    else if (above)      y = cy_w - row_off_w;
    else                 y = cy_w + row_off_w;
  end

  assign vis = !miss_r && !((x2 < left_w) || (x1 > right_w) ||
                            (y < top_w) || (y > bottom_w));
  assign x1c = (x1 < left_w)  ? left_w  : x1;
  assign x2c = (x2 > right_w) ? right_w : x2;
  assign col = (scan_en_r && y[0]) ?
               {rgba_r[dsr_pkg::RGBA_W-1:dsr_pkg::ALPHA_W], alpha_sh_r} : rgba_r;

  assign status.last = span_last;

  // result register
  logic                       strobe_r, vis_r, last_r;
  logic signed [dsr_pkg::OUT_W-1:0] row_r, xs_r, xe_r;
  logic [dsr_pkg::RGBA_W-1:0] col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      vis_r  <= vis;
      row_r  <= vis ? y[dsr_pkg::OUT_W-1:0]   : '0;
      xs_r   <= vis ? x1c[dsr_pkg::OUT_W-1:0] : '0;
      xe_r   <= vis ? x2c[dsr_pkg::OUT_W-1:0] : '0;
      col_r  <= vis ? col : '0;
      last_r <= span_last;
    end
  end

  assign out_strobe    = strobe_r;
  assign out_visible   = vis_r;
  assign out_row       = row_r;
  assign out_x_start   = xs_r;
  assign out_x_end     = xe_r;
  assign out_span_rgba = col_r;
  assign out_last      = last_r;

endmodule

[sv/diamond_span_rasterizer.sv]
// ----------------------------------------------------------------------------
// diamond_span_rasterizer - filled diamond to clipped horizontal spans
// A draw command (centre, radius, colour) becomes one span beat per cycle.
// ----------------------------------------------------------------------------
// Usage notes:
//  - Command: drive in_* and raise start; it is taken on an edge where busy
//    is low. busy then stays high until the final span beat is registered.
//  - Results: one span per out_strobe cycle, centre row first, then the row
//    above and below for each half-width from 0 upwards; out_last marks the
//    final beat. The receiver cannot stall: each beat lasts one cycle only.
//  - Set-up: after the accepting edge the mul and prep states scale alpha
//    by shade/100 and check the bounding box, then the first beat follows.
//  - Beats: 2*radius+1 per command, one beat when the clip rectangle is
//    empty or missed; a new command is not taken until the walker has
//    emitted the final beat and busy is low again.
//  - Config: cfg_we/cfg_index/cfg_wdata write a clip or shade register at
//    once; write only while busy is low and no beat is outstanding.
//  - Reset (rst_n low, synchronous): idle, clip = full 4096x4096 at origin,
//    scanline shading off, shade 100%.
// ----------------------------------------------------------------------------
module diamond_span_rasterizer #(
  parameter int unsigned MAX_RADIUS = dsr_pkg::MAX_RADIUS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [dsr_pkg::CENTER_W-1:0]   in_center_x,
  input  logic signed [dsr_pkg::CENTER_W-1:0]   in_center_y,
  input  logic        [dsr_pkg::RADIUS_W-1:0]   in_radius,
  input  logic        [dsr_pkg::RGBA_W-1:0]     in_rgba,
  input  logic                                  cfg_we,
  input  logic        [dsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [dsr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                                  out_strobe,
  output logic                                  out_visible,
  output logic signed [dsr_pkg::OUT_W-1:0]      out_row,
  output logic signed [dsr_pkg::OUT_W-1:0]      out_x_start,
  output logic signed [dsr_pkg::OUT_W-1:0]      out_x_end,
  output logic        [dsr_pkg::RGBA_W-1:0]     out_span_rgba,
  output logic                                  out_last
);

  // sequencer commands and span-walker status
  dsr_pkg::dsr_cmd_t    cmd;
  dsr_pkg::dsr_status_t status;

  dsr_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  // clip registers, held command, alpha scaler and result register
  dsr_datapath #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_center_x   (in_center_x),
    .in_center_y   (in_center_y),
    .in_radius     (in_radius),
    .in_rgba       (in_rgba),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_strobe    (out_strobe),
    .out_visible   (out_visible),
    .out_row       (out_row),
    .out_x_start   (out_x_start),
    .out_x_end     (out_x_end),
    .out_span_rgba (out_span_rgba),
    .out_last      (out_last)
  );

endmodule
